// ===== sv/thpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the track hit probability estimator.
// No dependencies; every other file imports this package.
package thpe_pkg;

    // scan window length
    localparam int WINDOW = 40;

    // internal count and pointer widths
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = $clog2(WINDOW);

    // field widths of the ports
    localparam int OUT_CNT_W = 6;
    localparam int PROB_W    = 16;
    localparam int MISS_W    = 4;
    localparam int MINEXP_W  = 6;
    localparam int CFG_D_W   = 6;

    // Q1.15 scaling: dividend is hits shifted left by FRAC_W
    localparam int FRAC_W = 15;
    localparam int DIV_W  = CNT_W + FRAC_W;
    localparam int STEP_W = $clog2(DIV_W);

    // width for comparing a count with min_expected
    localparam int CMP_W = (CNT_W > MINEXP_W) ? CNT_W : MINEXP_W;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MISS_LIMIT   = 1'b0,
        CFG_MIN_EXPECTED = 1'b1
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_DIV_P,
        S_WAIT_P,
        S_DIV_S,
        S_WAIT_S,
        S_LOAD
    } t_state;

    // channel status seen by the sequencer
    typedef struct packed {
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] expect_cnt;
        logic             tracking;
    } t_chan_stat;

endpackage

// ===== sv/thpe_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: scan input, result output, config write.
// Depends on thpe_pkg for field widths.

interface thpe_in_if import thpe_pkg::*; ();
    logic valid;
    logic ready;
    logic primary_hit;
    logic secondary_hit;

    modport source (output valid, primary_hit, secondary_hit, input ready);
    modport sink   (input valid, primary_hit, secondary_hit, output ready);
endinterface

interface thpe_out_if import thpe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_CNT_W-1:0] primary_hits;
    logic [OUT_CNT_W-1:0] primary_expected;
    logic [PROB_W-1:0]    primary_prob;
    logic                 primary_valid;
    logic [OUT_CNT_W-1:0] secondary_hits;
    logic [OUT_CNT_W-1:0] secondary_expected;
    logic [PROB_W-1:0]    secondary_prob;
    logic                 secondary_valid;

    modport source (output valid, primary_hits, primary_expected, primary_prob,
                    primary_valid, secondary_hits, secondary_expected,
                    secondary_prob, secondary_valid, input ready);
    modport sink   (input valid, primary_hits, primary_expected, primary_prob,
                    primary_valid, secondary_hits, secondary_expected,
                    secondary_prob, secondary_valid, output ready);
endinterface

interface thpe_cfg_if import thpe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [0:0]         index;
    logic [CFG_D_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/thpe_chan.sv =====
`timescale 1ns / 1ps
// One channel: hit window ring, counts, miss run and tracking flag.
// Depends on thpe_pkg.
module thpe_chan import thpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [MISS_W-1:0] i_miss_limit,
    input  logic              i_rd,
    input  logic              i_upd,
    input  logic              i_hit,
    output t_chan_stat        o_stat
);

    // window ring memory, with a valid flag per entry so unwritten bits read as zero
    logic r_win [WINDOW];
    logic r_wv  [WINDOW];
    logic r_old;

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_hits, n_hits;
    logic [CNT_W-1:0]  r_exp, n_exp;
    logic [MISS_W-1:0] r_miss, n_miss;
    logic              r_trk, n_trk;

    logic              full;
    logic [CNT_W-1:0]  hits1;
    logic [CNT_W-1:0]  exp1;

    // read the slot that may drop out of the window
    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_old <= r_win[r_slot] & r_wv[r_slot];
        end
    end

    // write the new hit bit
    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            r_win[r_slot] <= i_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_wv[k] <= 1'b0;
            end
        end else if (i_upd) begin
            r_wv[r_slot] <= 1'b1;
        end
    end

    // scan update
    always_comb begin
        full  = (r_exp == CNT_W'(WINDOW));
        exp1  = full ? CNT_W'(WINDOW - 1) : r_exp;
        hits1 = (full && r_old && (r_hits != '0)) ? r_hits - CNT_W'(1) : r_hits;

        n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
        n_hits = hits1;
        n_exp  = exp1;
        n_miss = r_miss;
        n_trk  = r_trk;

        if (i_hit) begin
            n_miss = '0;
            if (r_trk) begin
                n_hits = hits1 + CNT_W'(1);
                n_exp  = exp1 + CNT_W'(1);
            end else begin
                n_hits = CNT_W'(1);
                n_exp  = CNT_W'(1);
                n_trk  = 1'b1;
            end
        end else if (r_trk) begin
            if (r_miss == i_miss_limit) begin
                // too many misses: drop the track, window bits stay
                n_miss = '0;
                n_hits = '0;
                n_exp  = '0;
                n_trk  = 1'b0;
                n_slot = '0;
            end else begin
                n_miss = r_miss + MISS_W'(1);
                n_exp  = exp1 + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_hits <= '0;
            r_exp  <= '0;
            r_miss <= '0;
            r_trk  <= 1'b0;
        end else if (i_upd) begin
            r_slot <= n_slot;
            r_hits <= n_hits;
            r_exp  <= n_exp;
            r_miss <= n_miss;
            r_trk  <= n_trk;
        end
    end

    assign o_stat.hits       = r_hits;
    assign o_stat.expect_cnt = r_exp;
    assign o_stat.tracking   = r_trk;

endmodule

// ===== sv/thpe_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: (hits << 15) / expected.
// Depends on thpe_pkg.
module thpe_div import thpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CNT_W-1:0]  i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [PROB_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_q;
    logic              r_zero;

    logic [CNT_W:0]    trial;
    logic              ge;
    logic [CNT_W:0]    diff;

    // one restoring step
    always_comb begin
        trial = {r_rem, r_q[DIV_W-1]};
        ge    = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend bits shift out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= {i_dividend, FRAC_W'(0)};
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], ge};
        end
    end

    // zero expected count reads as zero probability
    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_q[PROB_W-1:0];

endmodule

// ===== sv/track_hit_probability_estimator_unit.sv =====
`timescale 1ns / 1ps
// Top level: sequencer, config registers, output register, two channels, shared divider.
// Depends on thpe_pkg, thpe_if, thpe_chan, thpe_div.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-------------------------------------
//  i_in     | in  | valid/ready           | primary_hit, secondary_hit
//  o_out    | out | valid/ready           | hits, expected, prob, valid per channel
//  i_cfg    | in  | valid/ready (ready=1) | index (0 miss_limit, 1 min_expected), data
//
// An item goes from acceptance to result in these steps: the window ring is
// read as the item is accepted, both channels update, then the shared divider
// runs one quotient bit per cycle, primary then secondary.
// Input ready is high only while the sequencer is idle. A finished result sits
// in the output register and the next item may be accepted meanwhile; the
// sequencer holds its result until the register frees. Reset is synchronous
// and needs no clearing pass.
module track_hit_probability_estimator_unit import thpe_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    thpe_in_if.sink       i_in,
    thpe_out_if.source    o_out,
    thpe_cfg_if.sink      i_cfg
);

    t_state r_state, n_state;

    logic                r_hit_p;
    logic                r_hit_s;
    logic [MISS_W-1:0]   r_miss_limit;
    logic [MINEXP_W-1:0] r_min_exp;
    logic [PROB_W-1:0]   r_prob_p;

    logic                in_acc;
    logic                upd;
    logic                div_start;
    logic [CNT_W-1:0]    div_dividend;
    logic [CNT_W-1:0]    div_divisor;
    logic                div_done;
    logic [PROB_W-1:0]   div_quot;
    logic                load;

    t_chan_stat          stat_p;
    t_chan_stat          stat_s;

    logic [CMP_W-1:0]    exp_p_x;
    logic [CMP_W-1:0]    exp_s_x;
    logic [CMP_W-1:0]    hits_p_x;
    logic [CMP_W-1:0]    hits_s_x;
    logic [CMP_W-1:0]    min_x;

    logic                r_o_valid;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_limit <= MISS_W'(10);
            r_min_exp    <= MINEXP_W'(10);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MISS_LIMIT:   r_miss_limit <= i_cfg.data[MISS_W-1:0];
                CFG_MIN_EXPECTED: r_min_exp    <= i_cfg.data[MINEXP_W-1:0];
                default: ;
            endcase
        end
    end

    // latch the scan's hit flags
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hit_p <= i_in.primary_hit;
            r_hit_s <= i_in.secondary_hit;
        end
    end

    thpe_chan u_chan_p (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_miss_limit (r_miss_limit),
        .i_rd         (in_acc),
        .i_upd        (upd),
        .i_hit        (r_hit_p),
        .o_stat       (stat_p)
    );

    thpe_chan u_chan_s (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_miss_limit (r_miss_limit),
        .i_rd         (in_acc),
        .i_upd        (upd),
        .i_hit        (r_hit_s),
        .o_stat       (stat_s)
    );

    thpe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        upd          = 1'b0;
        div_start    = 1'b0;
        div_dividend = stat_p.hits;
        div_divisor  = stat_p.expect_cnt;
        load         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_UPD;
            end
            S_UPD: begin
                upd     = 1'b1;
                n_state = S_DIV_P;
            end
            S_DIV_P: begin
                div_start = 1'b1;
                n_state   = S_WAIT_P;
            end
            S_WAIT_P: begin
                if (div_done) n_state = S_DIV_S;
            end
            S_DIV_S: begin
                div_start    = 1'b1;
                div_dividend = stat_s.hits;
                div_divisor  = stat_s.expect_cnt;
                n_state      = S_WAIT_S;
            end
            S_WAIT_S: begin
                if (div_done) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (!r_o_valid || o_out.ready) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // keep the primary quotient while the secondary one is worked out
    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT_P && div_done) begin
            r_prob_p <= div_quot;
        end
    end

    assign exp_p_x  = CMP_W'(stat_p.expect_cnt);
    assign exp_s_x  = CMP_W'(stat_s.expect_cnt);
    assign hits_p_x = CMP_W'(stat_p.hits);
    assign hits_s_x = CMP_W'(stat_s.hits);
    assign min_x    = CMP_W'(r_min_exp);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_out.primary_hits       <= hits_p_x[OUT_CNT_W-1:0];
            o_out.primary_expected   <= exp_p_x[OUT_CNT_W-1:0];
            o_out.primary_prob       <= r_prob_p;
            o_out.primary_valid      <= stat_p.tracking && (exp_p_x >= min_x);
            o_out.secondary_hits     <= hits_s_x[OUT_CNT_W-1:0];
            o_out.secondary_expected <= exp_s_x[OUT_CNT_W-1:0];
            o_out.secondary_prob     <= div_quot;
            o_out.secondary_valid    <= stat_s.tracking && (exp_s_x >= min_x);
        end
    end

    assign o_out.valid = r_o_valid;

endmodule
